@@ sv/matrix_vector_multiply_unit_assert.svh @@
// Assertion macros for the matrix-vector multiply unit checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MVM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mvm assertion failed");

// Check a property on every rising clock edge, reset included.
`define MVM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mvm assertion failed");

`endif

@@ sv/mvm_pkg.sv @@
// Shared types and constants of the matrix-vector multiply unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package mvm_pkg;

    localparam int unsigned MAX_SIZE_DEFAULT = 16;
    localparam int unsigned SIZE_LIMIT       = 16;
    localparam int unsigned CFG_W            = 5;
    localparam int unsigned IDX_W            = 4;
    localparam int unsigned VAL_W            = 16;
    localparam int unsigned PROD_W           = 32;
    localparam int unsigned SUM_W            = 36;
    localparam int unsigned QUEUE_DEPTH      = 4;
    // Accept edge to the edge that ends the result strobe cycle.
    localparam int unsigned RESULT_LATENCY   = 4;

    localparam logic OPC_LOAD   = 1'b0;
    localparam logic OPC_MATRIX = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_mvm_in;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_row;
    } t_mvm_out;

    // One classified request between front and back.
    typedef struct packed {
        logic                    is_load;
        logic [IDX_W-1:0]        addr;
        logic signed [VAL_W-1:0] value;
        logic                    end_row;
        logic [IDX_W-1:0]        row;
        logic                    last_row;
    } t_mvm_op;

endpackage

`default_nettype wire

@@ sv/mvm_queue.sv @@
// Small FIFO of classified requests between the front and the back.
// Depends on mvm_pkg for the request type.
`default_nettype none

module mvm_queue #(
    parameter int unsigned DEPTH = mvm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mvm_pkg::t_mvm_op i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output mvm_pkg::t_mvm_op o_data
);
    import mvm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_mvm_op            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == CNT_W'(DEPTH));
        o_empty = (r_cnt == '0);
        o_data  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ sv/mvm_front.sv @@
// Front end: accepts commands, holds the size register and the row/column
// counters, and turns each command into a request. Depends on mvm_pkg.
`default_nettype none

module mvm_front #(
    parameter int unsigned MAX_SIZE = mvm_pkg::MAX_SIZE_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_full,
    input  mvm_pkg::t_mvm_in          i_cmd,
    input  logic                      i_cfg_we,
    input  logic [mvm_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_push,
    output mvm_pkg::t_mvm_op          o_op
);
    import mvm_pkg::*;

    localparam int unsigned ORDER_LIMIT = (MAX_SIZE < SIZE_LIMIT) ? MAX_SIZE : SIZE_LIMIT;

    logic [CFG_W-1:0] r_order, n_order;
    logic [IDX_W-1:0] r_col, n_col, r_row, n_row;
    logic [IDX_W-1:0] col_eff, row_eff;
    logic             accept, end_row, last_row, load_ok;

    always_comb begin
        accept   = i_start && !i_full;
        col_eff  = ({1'b0, r_col} >= r_order) ? '0 : r_col;
        row_eff  = ({1'b0, r_row} >= r_order) ? '0 : r_row;
        end_row  = ({1'b0, col_eff} + CFG_W'(1)) >= r_order;
        last_row = ({1'b0, row_eff} + CFG_W'(1)) >= r_order;
        load_ok  = 32'(i_cmd.index) < MAX_SIZE;

        n_order = r_order;
        n_col   = r_col;
        n_row   = r_row;
        o_push  = 1'b0;
        o_op    = '0;
        o_op.value = i_cmd.value;

        if (accept) begin
            if (i_cmd.opcode == OPC_LOAD) begin
                // drop loads past the end of the store
                o_push       = load_ok;
                o_op.is_load = 1'b1;
                o_op.addr    = i_cmd.index;
            end else begin
                o_push        = 1'b1;
                o_op.addr     = col_eff;
                o_op.end_row  = end_row;
                o_op.row      = row_eff;
                o_op.last_row = end_row && last_row;
                if (end_row) begin
                    n_col = '0;
                    n_row = last_row ? '0 : row_eff + IDX_W'(1);
                end else begin
                    n_col = col_eff + IDX_W'(1);
                    n_row = row_eff;
                end
            end
        end

        // a size write restarts the matrix
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
            if (i_cfg_wdata == '0) begin
                n_order = CFG_W'(1);
            end else if (32'(i_cfg_wdata) > ORDER_LIMIT) begin
                n_order = CFG_W'(ORDER_LIMIT);
            end else begin
                n_order = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= CFG_W'(ORDER_LIMIT);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_order <= n_order;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ sv/mvm_back.sv @@
// Back end: vector store, registered multiply and row accumulator.
// Takes one request per cycle from the queue. Depends on mvm_pkg.
`default_nettype none

module mvm_back #(
    parameter int unsigned MAX_SIZE = mvm_pkg::MAX_SIZE_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mvm_pkg::t_mvm_op  i_op,
    input  logic              i_clear,
    output logic              o_pop,
    output logic              o_valid,
    output mvm_pkg::t_mvm_out o_result
);
    import mvm_pkg::*;

    localparam int unsigned STORE_DEPTH = (MAX_SIZE < SIZE_LIMIT) ? MAX_SIZE : SIZE_LIMIT;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

    logic signed [VAL_W-1:0]  r_store [STORE_DEPTH];
    logic signed [VAL_W-1:0]  r_s1_data;
    t_mvm_op                  r_s1_op;
    logic                     r_s1_valid;
    logic signed [PROD_W-1:0] r_s2_prod, n_prod;
    t_mvm_op                  r_s2_op;
    logic                     r_s2_valid;
    logic signed [SUM_W-1:0]  r_acc, n_acc, n_sum;
    logic                     r_valid, n_valid;
    t_mvm_out                 r_result, n_result;

    assign o_pop    = i_valid;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // store write for loads, registered read for matrix elements
    always_ff @(posedge i_clk) begin
        if (i_valid && i_op.is_load) begin
            r_store[i_op.addr[ADDR_W-1:0]] <= i_op.value;
        end
        r_s1_data <= r_store[i_op.addr[ADDR_W-1:0]];
        r_s1_op   <= i_op;
        r_s2_prod <= n_prod;
        r_s2_op   <= r_s1_op;
        r_result  <= n_result;
    end

    always_comb begin
        n_prod = $signed(r_s1_op.value) * $signed(r_s1_data);
        n_sum  = r_acc + $signed({{(SUM_W - PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod});

        n_acc = r_acc;
        if (r_s2_valid) begin
            n_acc = r_s2_op.end_row ? '0 : n_sum;
        end
        if (i_clear) begin
            n_acc = '0;
        end

        n_valid            = r_s2_valid && r_s2_op.end_row;
        n_result.row_index = r_s2_op.row;
        n_result.row_sum   = n_sum;
        n_result.last_row  = r_s2_op.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_valid    <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_valid <= i_valid && !i_op.is_load;
            r_s2_valid <= r_s1_valid;
            r_valid    <= n_valid;
            r_acc      <= n_acc;
        end
    end

endmodule

`default_nettype wire

@@ sv/matrix_vector_multiply_unit.sv @@
// Result path: a matrix element that closes a row passes the queue write (at its accept
// edge), the store read, the multiply and the accumulate register in that order, and
// its row sum is then strobed on o_valid. Loads give none.
// Throughput: one command per cycle; the back end drains one queue entry per
// cycle, so busy stays low under any command stream.
// Reset: size goes to the largest order, counters and accumulator clear, and
// the vector store holds nothing valid until loaded (no clearing pass).
`default_nettype none

module matrix_vector_multiply_unit #(
    parameter int unsigned MAX_SIZE = mvm_pkg::MAX_SIZE_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mvm_pkg::t_mvm_in          i_cmd,
    input  logic                      i_cfg_we,
    input  logic [mvm_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_valid,
    output mvm_pkg::t_mvm_out         o_result
);
    import mvm_pkg::*;

    logic    push, pop, q_full, q_empty;
    t_mvm_op front_op, back_op;

    mvm_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_full      (q_full),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_op        (front_op)
    );

    mvm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (back_op)
    );

    mvm_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_op     (back_op),
        .i_clear  (i_cfg_we),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign busy = q_full;

endmodule

`default_nettype wire

@@ sv/mvm_checker.sv @@
// Port-level checker for the matrix-vector multiply unit, bound to the top.
// Depends on mvm_pkg and matrix_vector_multiply_unit_assert.svh.
`default_nettype none
`include "matrix_vector_multiply_unit_assert.svh"

module mvm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input mvm_pkg::t_mvm_in i_cmd,
    input logic             o_valid
);
    import mvm_pkg::*;

    logic take_matrix, take_load;

    assign take_matrix = start && !busy && (i_cmd.opcode == OPC_MATRIX);
    assign take_load   = start && !busy && (i_cmd.opcode == OPC_LOAD);

    // quiet outputs right after reset
    `MVM_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> (!o_valid && !busy))
    // every strobe comes from a matrix element accepted a fixed time earlier
    `MVM_ASSERT(a_result_source, i_clk, i_rst_n, o_valid |-> $past(take_matrix, RESULT_LATENCY))
    // a vector load never yields a result
    `MVM_ASSERT(a_load_silent, i_clk, i_rst_n, $past(take_load, RESULT_LATENCY) |-> !o_valid)

endmodule

bind matrix_vector_multiply_unit mvm_checker u_mvm_checker (.*);

`default_nettype wire

@@ sim/matrix_vector_multiply_unit_tb.sv @@
// Self-checking testbench for the matrix-vector multiply unit: directed and random
// command streams, checked row sum by row sum against an in-bench predictor (Q8.8 in, Q20.16 sums).
// Depends on mvm_pkg and matrix_vector_multiply_unit.

module matrix_vector_multiply_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mvm_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_mvm_in               cmd_bus;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  o_valid;
    t_mvm_out              o_result;

    // Predictor state
    logic signed [VAL_W-1:0] vec_shadow [SIZE_LIMIT];
    longint                  row_acc;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [CFG_W-1:0]        order_reg;
    t_mvm_out                expected_rows [$];

    int unsigned error_count    = 0;
    int unsigned requests_taken = 0;
    int unsigned rows_checked   = 0;
    int unsigned stall_cycles   = 0;
    int unsigned sender_idle_pct = 0;

    matrix_vector_multiply_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned eff_order(logic [CFG_W-1:0] s);
        int unsigned lim;
        int unsigned n;
        lim = (MAX_SIZE_DEFAULT < SIZE_LIMIT) ? MAX_SIZE_DEFAULT : SIZE_LIMIT;
        n = s;
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        return n;
    endfunction

    function void restart_matrix();
        row_acc = 0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Advance the predictor by one accepted request; queue a row sum when a row closes.
    function void predict_row_sum(t_mvm_in c);
        int unsigned n;
        longint      sum;
        t_mvm_out    row_out;
        if (c.opcode == OPC_LOAD) begin
            vec_shadow[c.index] = c.value;
            return;
        end
        n = eff_order(order_reg);
        if (col_pos >= n) col_pos = 0;
        if (row_pos >= n) row_pos = 0;
        sum = row_acc + longint'(c.value) * longint'(vec_shadow[col_pos]);
        if (col_pos + 1 < n) begin
            row_acc = sum;
            col_pos++;
        end else begin
            row_out.row_index = row_pos[IDX_W-1:0];
            row_out.row_sum   = sum[SUM_W-1:0];
            row_out.last_row  = (row_pos + 1 >= n);
            expected_rows.push_back(row_out);
            row_acc = 0;
            col_pos = 0;
            row_pos = row_out.last_row ? 0 : row_pos + 1;
        end
    endfunction

    // Monitor: check results, track accepted requests and register writes, watchdog.
    always @(posedge i_clk) begin
        t_mvm_out exp_row;
        logic     active;
        active = 1'b0;
        if (!i_rst_n) begin
            order_reg = CFG_W'(SIZE_LIMIT);
            restart_matrix();
        end else begin
            if (o_valid === 1'b1) begin
                active = 1'b1;
                if (expected_rows.size() == 0) begin
                    error_count++;
                    $error("unexpected row sum: row_index %0d row_sum %0d last_row %0b",
                           o_result.row_index, o_result.row_sum, o_result.last_row);
                end else begin
                    exp_row = expected_rows.pop_front();
                    rows_checked++;
                    if (o_result.row_index !== exp_row.row_index) begin
                        error_count++;
                        $error("row_index: expected %0d, got %0d",
                               exp_row.row_index, o_result.row_index);
                    end
                    if (o_result.row_sum !== exp_row.row_sum) begin
                        error_count++;
                        $error("row_sum: expected %0d, got %0d",
                               exp_row.row_sum, o_result.row_sum);
                    end
                    if (o_result.last_row !== exp_row.last_row) begin
                        error_count++;
                        $error("last_row: expected %0b, got %0b",
                               exp_row.last_row, o_result.last_row);
                    end
                end
            end
            if (cfg_we) begin
                active = 1'b1;
                order_reg = cfg_wdata;
                restart_matrix();
            end
            if (start && !busy) begin
                active = 1'b1;
                requests_taken++;
                predict_row_sum(cmd_bus);
            end
        end
        if (active) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_mvm_in mk_cmd(logic opc, logic [IDX_W-1:0] idx,
                                       logic signed [VAL_W-1:0] val);
        t_mvm_in c;
        c.opcode = opc;
        c.index  = idx;
        c.value  = val;
        return c;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_q88();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return (r[0]) ? 16'sd1 : -16'sd1;
            default: return r[VAL_W-1:0];
        endcase
    endfunction

    // Send one request; hold it until accepted. Each cycle idles with the set odds.
    task automatic send_cmd(t_mvm_in c);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        cmd_bus <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending, wait for every row sum, then let the pipeline empty out.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_rows.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_order(logic [CFG_W-1:0] s);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_vector_load();
        for (int i = 0; i < SIZE_LIMIT; i++)
            send_cmd(mk_cmd(OPC_LOAD, IDX_W'(i), -16'sd32768));
    endtask

    // Reset order is 16: one full row of extremes gives the largest positive sum.
    task automatic test_reset_order();
        for (int i = 0; i < SIZE_LIMIT; i++)
            send_cmd(mk_cmd(OPC_MATRIX, IDX_W'($urandom), -16'sd32768));
        drain();
    endtask

    // Order 0 acts as 1; the write also abandons the matrix in progress.
    task automatic test_order_zero();
        write_order('0);
        send_cmd(mk_cmd(OPC_MATRIX, 4'hF, 16'sd32767));
        send_cmd(mk_cmd(OPC_MATRIX, 4'h0, -16'sd32768));
        drain();
    endtask

    // A load in the middle of a row takes effect for the columns after it.
    task automatic test_load_mid_row();
        write_order(5'd2);
        send_cmd(mk_cmd(OPC_MATRIX, 4'h3, 16'sd1));
        send_cmd(mk_cmd(OPC_LOAD, 4'h1, 16'sd32767));
        send_cmd(mk_cmd(OPC_MATRIX, 4'h0, -16'sd32768));
        send_cmd(mk_cmd(OPC_LOAD, 4'h0, 16'sd256));
        send_cmd(mk_cmd(OPC_MATRIX, 4'h0, 16'sd256));
        send_cmd(mk_cmd(OPC_MATRIX, 4'hA, 16'sd256));
        // wrap straight into a new matrix
        send_cmd(mk_cmd(OPC_MATRIX, 4'h5, -16'sd1));
        send_cmd(mk_cmd(OPC_MATRIX, 4'h5, 16'sd32767));
        drain();
    endtask

    function automatic logic [CFG_W-1:0] pick_order();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return CFG_W'($urandom_range(1, 4));
        if (r < 85) return CFG_W'($urandom_range(5, 8));
        if (r < 92) return CFG_W'(SIZE_LIMIT);
        if (r < 96) return '0;
        return CFG_W'($urandom_range(17, 31));
    endfunction

    task automatic test_random_phase(int unsigned idle_pct, int unsigned n_items);
        int unsigned      sent;
        int unsigned      n;
        int unsigned      total;
        logic [CFG_W-1:0] s;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < n_items) begin
            s = pick_order();
            drain();
            write_order(s);
            n = eff_order(s);
            repeat ($urandom_range(0, n)) begin
                send_cmd(mk_cmd(OPC_LOAD, IDX_W'($urandom), rand_q88()));
                sent++;
            end
            total = (n > 8) ? n * n : $urandom_range(1, 3) * n * n;
            // abandon some matrices partway through
            if ($urandom_range(9) == 0 || (n > 8 && $urandom_range(1) == 0))
                total = $urandom_range(1, total);
            for (int e = 0; e < total && sent < n_items; e++) begin
                if ($urandom_range(15) == 0) begin
                    send_cmd(mk_cmd(OPC_LOAD, IDX_W'($urandom), rand_q88()));
                    sent++;
                end
                send_cmd(mk_cmd(OPC_MATRIX, IDX_W'($urandom), rand_q88()));
                sent++;
                if ($urandom_range(99) == 0) drain();
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd_bus   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_vector_load();
        test_reset_order();
        test_order_zero();
        test_load_mid_row();
        test_random_phase(14, PHASE_ITEMS);
        test_random_phase(71, PHASE_ITEMS);
        test_random_phase(0, PHASE_ITEMS);
        drain();

        $display("Run covered %0d requests and %0d row sums over orders 0 to 31,",
                 requests_taken, rows_checked);
        $display("with loads inside rows, abandoned matrices and back-to-back matrices.");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
